/* hdl/csu_pkg.sv */
// Shared constants, types and codes of the counting semaphore unit.
`timescale 1ns / 1ps

package csu_pkg;

    // Size of the semaphore bank and of each wait queue.
    localparam int NUM_SEMS    = 8;
    localparam int QUEUE_DEPTH = 16;

    // Fixed field widths of the interface.
    localparam int SEM_W    = 3;
    localparam int ID_W     = 8;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int SEMS_DEF_W = 4;

    // Derived widths.
    localparam int SEM_AW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = $clog2(2 * QUEUE_DEPTH);
    localparam int WAITER_DEPTH = NUM_SEMS * QUEUE_DEPTH;
    localparam int WADDR_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WAITER_W = 2 * ID_W;

    // Operation codes.
    localparam logic OP_WAIT   = 1'b0;
    localparam logic OP_SIGNAL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SEMS_DEFINED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNTS     = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UNKNOWN     = 3'd0,
        STATUS_TAKEN       = 3'd1,
        STATUS_QUEUED      = 3'd2,
        STATUS_WOKEN       = 3'd3,
        STATUS_INCREMENTED = 3'd4,
        STATUS_NO_CHANGE   = 3'd5
    } status_t;

    // Per-semaphore queue bookkeeping, kept in one memory word.
    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [LEN_W-1:0]  len;
    } queue_meta_t;

    localparam int META_W = $bits(queue_meta_t);

endpackage

/* hdl/csu_ram.sv */
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/counting_semaphore_unit_core.sv */
// Top level of the counting semaphore unit: control, counts and queue memories.
`timescale 1ns / 1ps

// The unit holds a bank of counting semaphores, each with an 8-bit count, an
// 8-bit maximum and a FIFO queue of waiting callers (process id and thread id).
// A wait item takes one unit when the count is positive and otherwise queues
// the caller, or reports a full queue. A signal item wakes the oldest waiter
// when the count is zero and the queue holds someone, and otherwise raises
// the count up to its maximum. Every item yields exactly one result item.
// Items are handled one at a time. For a wait, or a signal that does not
// wake anyone, the bookkeeping memory is read in the cycle the item is
// accepted, and the decide step that follows decides, writes back and
// loads the result into the output register. A signal that wakes a waiter
// reads the waiter store in its decide step and loads its result in the
// wake step after it, since the waiter store is read after the bookkeeping
// word. The next item is accepted as soon as the unit is back in its idle
// state, even while the previous result still waits in the output
// register; a full output register holds the unit in its decide step and,
// for a wake, also in its wake step. Queue bookkeeping resets
// to empty through per-semaphore valid bits, so no clearing pass is needed
// and items are accepted right after reset. The waiter store is never
// cleared; only entries written by a wait are ever read back. Writing the
// initial counts register reloads all counts at once but leaves the queues
// as they are. Configuration is meant to be written only while the unit
// is idle.

module counting_semaphore_unit_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csu_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic [csu_pkg::SEM_W-1:0]           s_sem_index,
    input  logic [csu_pkg::ID_W-1:0]            s_proc_id,
    input  logic [csu_pkg::ID_W-1:0]            s_thread_id,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [csu_pkg::STATUS_W-1:0]        m_status,
    output logic [csu_pkg::COUNT_W-1:0]         m_count_after,
    output logic [csu_pkg::ID_W-1:0]            m_woken_proc,
    output logic [csu_pkg::ID_W-1:0]            m_woken_thread
);

    // Control sequence: IDLE takes an item and starts the bookkeeping read,
    // DECIDE acts on the read data, WAKE returns the dequeued waiter.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECIDE = 3'b010,
        ST_WAKE   = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Accepted item.
    logic                          op_reg;
    logic [csu_pkg::SEM_W-1:0]     sem_reg;
    logic [csu_pkg::ID_W-1:0]      pid_reg;
    logic [csu_pkg::ID_W-1:0]      tid_reg;

    // Configuration.
    logic [csu_pkg::SEMS_DEF_W-1:0] sems_defined_reg;
    logic [csu_pkg::CFG_DATA_W-1:0] max_counts_reg;

    // Counts live in flip-flops because a configuration write reloads all of them.
    logic [csu_pkg::COUNT_W-1:0]   counts_reg [csu_pkg::NUM_SEMS];
    logic [csu_pkg::NUM_SEMS-1:0]  meta_vld_reg;

    // Output register.
    logic                          m_valid_reg;
    logic [csu_pkg::STATUS_W-1:0]  m_status_reg;
    logic [csu_pkg::COUNT_W-1:0]   m_count_reg;
    logic [csu_pkg::ID_W-1:0]      m_wproc_reg;
    logic [csu_pkg::ID_W-1:0]      m_wthread_reg;

    // Memory ports.
    logic                          meta_we, meta_re;
    logic [csu_pkg::SEM_AW-1:0]    meta_raddr;
    csu_pkg::queue_meta_t          meta_wdata;
    logic [csu_pkg::META_W-1:0]    meta_rdata;
    logic                          wst_we, wst_re;
    logic [csu_pkg::WADDR_W-1:0]   wst_addr;
    logic [csu_pkg::WAITER_W-1:0]  wst_wdata;
    logic [csu_pkg::WAITER_W-1:0]  wst_rdata;

    // Decision signals.
    logic [csu_pkg::NUM_SEMS-1:0]  sem_hit;
    logic                          known;
    logic                          out_free;
    logic [csu_pkg::COUNT_W-1:0]   cur_count;
    logic [csu_pkg::COUNT_W-1:0]   cur_max;
    logic                          cur_vld;
    csu_pkg::queue_meta_t          cur_meta;
    logic [csu_pkg::SUM_W-1:0]     slot_sum;
    logic [csu_pkg::HEAD_W-1:0]    tail_slot;
    logic [csu_pkg::HEAD_W-1:0]    head_inc;
    logic [csu_pkg::WADDR_W-1:0]   sem_base;
    logic                          cnt_we;
    logic [csu_pkg::COUNT_W-1:0]   cnt_wdata;
    logic                          res_load;
    csu_pkg::status_t              res_status;
    logic [csu_pkg::COUNT_W-1:0]   res_count;
    logic [csu_pkg::ID_W-1:0]      res_wproc;
    logic [csu_pkg::ID_W-1:0]      res_wthread;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    // Per-semaphore bookkeeping: head and length of each wait queue.
    csu_ram #(
        .WIDTH (csu_pkg::META_W),
        .DEPTH (csu_pkg::NUM_SEMS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (sem_reg[csu_pkg::SEM_AW-1:0]),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Waiter store: one row of QUEUE_DEPTH entries per semaphore.
    csu_ram #(
        .WIDTH (csu_pkg::WAITER_W),
        .DEPTH (csu_pkg::WAITER_DEPTH)
    ) u_waiter_ram (
        .aclk  (aclk),
        .we    (wst_we),
        .waddr (wst_addr),
        .wdata (wst_wdata),
        .re    (wst_re),
        .raddr (wst_addr),
        .rdata (wst_rdata)
    );

    // Select the addressed semaphore's count, maximum and bookkeeping word.
    always_comb begin
        cur_count = '0;
        cur_vld   = 1'b0;
        for (int i = 0; i < csu_pkg::NUM_SEMS; i++) begin
            sem_hit[i] = (sem_reg == csu_pkg::SEM_W'(i));
            if (sem_hit[i]) begin
                cur_count = counts_reg[i];
                cur_vld   = meta_vld_reg[i];
            end
        end
        known    = ({1'b0, sem_reg} < sems_defined_reg) &&
                   (32'(sem_reg) < csu_pkg::NUM_SEMS);
        cur_max  = max_counts_reg[{sem_reg, 3'b000} +: csu_pkg::COUNT_W];
        // A queue whose word was never written is empty.
        cur_meta = cur_vld ? csu_pkg::queue_meta_t'(meta_rdata) : '0;

        slot_sum = csu_pkg::SUM_W'(cur_meta.head) + csu_pkg::SUM_W'(cur_meta.len);
        if (slot_sum >= csu_pkg::SUM_W'(csu_pkg::QUEUE_DEPTH)) begin
            tail_slot = csu_pkg::HEAD_W'(slot_sum - csu_pkg::SUM_W'(csu_pkg::QUEUE_DEPTH));
        end else begin
            tail_slot = csu_pkg::HEAD_W'(slot_sum);
        end
        if (cur_meta.head == csu_pkg::HEAD_W'(csu_pkg::QUEUE_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = cur_meta.head + 1'b1;
        end
        sem_base = csu_pkg::WADDR_W'(sem_reg) * csu_pkg::WADDR_W'(csu_pkg::QUEUE_DEPTH);
    end

    // Sequencer and read-modify-write of the addressed semaphore.
    always_comb begin
        state_next  = state_reg;
        meta_re     = 1'b0;
        meta_raddr  = s_sem_index[csu_pkg::SEM_AW-1:0];
        meta_we     = 1'b0;
        meta_wdata  = cur_meta;
        wst_we      = 1'b0;
        wst_re      = 1'b0;
        wst_addr    = sem_base + csu_pkg::WADDR_W'(tail_slot);
        wst_wdata   = {pid_reg, tid_reg};
        cnt_we      = 1'b0;
        cnt_wdata   = cur_count;
        res_load    = 1'b0;
        res_status  = csu_pkg::STATUS_UNKNOWN;
        res_count   = '0;
        res_wproc   = '0;
        res_wthread = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    meta_re    = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (!known) begin
                        res_status = csu_pkg::STATUS_UNKNOWN;
                    end else if (op_reg == csu_pkg::OP_WAIT) begin
                        if (cur_count != '0) begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cur_count - 1'b1;
                            res_status = csu_pkg::STATUS_TAKEN;
                            res_count  = cur_count - 1'b1;
                        end else if (cur_meta.len >=
                                     csu_pkg::LEN_W'(csu_pkg::QUEUE_DEPTH)) begin
                            res_status = csu_pkg::STATUS_NO_CHANGE;
                        end else begin
                            wst_we          = 1'b1;
                            meta_we         = 1'b1;
                            meta_wdata.len  = cur_meta.len + 1'b1;
                            res_status      = csu_pkg::STATUS_QUEUED;
                        end
                    end else begin
                        if (cur_count == '0 && cur_meta.len != '0) begin
                            // Dequeue the oldest waiter; its ids arrive next cycle.
                            wst_re          = 1'b1;
                            wst_addr        = sem_base + csu_pkg::WADDR_W'(cur_meta.head);
                            meta_we         = 1'b1;
                            meta_wdata.head = head_inc;
                            meta_wdata.len  = cur_meta.len - 1'b1;
                            res_load        = 1'b0;
                            state_next      = ST_WAKE;
                        end else if (cur_count < cur_max) begin
                            cnt_we     = 1'b1;
                            cnt_wdata  = cur_count + 1'b1;
                            res_status = csu_pkg::STATUS_INCREMENTED;
                            res_count  = cur_count + 1'b1;
                        end else begin
                            res_status = csu_pkg::STATUS_NO_CHANGE;
                            res_count  = cur_count;
                        end
                    end
                end
            end
            ST_WAKE: begin
                if (out_free) begin
                    res_load    = 1'b1;
                    res_status  = csu_pkg::STATUS_WOKEN;
                    res_wproc   = wst_rdata[csu_pkg::WAITER_W-1:csu_pkg::ID_W];
                    res_wthread = wst_rdata[csu_pkg::ID_W-1:0];
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            sems_defined_reg <= '0;
            max_counts_reg   <= '0;
            meta_vld_reg     <= '0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < csu_pkg::NUM_SEMS; i++) begin
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (meta_we) begin
                meta_vld_reg <= meta_vld_reg | sem_hit;
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    csu_pkg::CFG_SEMS_DEFINED: begin
                        sems_defined_reg <= cfg_data[csu_pkg::SEMS_DEF_W-1:0];
                    end
                    csu_pkg::CFG_INITIAL_COUNTS: begin
                        for (int i = 0; i < csu_pkg::NUM_SEMS; i++) begin
                            counts_reg[i] <= cfg_data[8 * (i % 8) +: csu_pkg::COUNT_W];
                        end
                    end
                    csu_pkg::CFG_MAX_COUNTS: begin
                        max_counts_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end else if (cnt_we) begin
                for (int i = 0; i < csu_pkg::NUM_SEMS; i++) begin
                    if (sem_hit[i]) begin
                        counts_reg[i] <= cnt_wdata;
                    end
                end
            end

            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            sem_reg <= s_sem_index;
            pid_reg <= s_proc_id;
            tid_reg <= s_thread_id;
        end
        if (res_load) begin
            m_status_reg  <= res_status;
            m_count_reg   <= res_count;
            m_wproc_reg   <= res_wproc;
            m_wthread_reg <= res_wthread;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_count_after  = m_count_reg;
    assign m_woken_proc   = m_wproc_reg;
    assign m_woken_thread = m_wthread_reg;

endmodule

/* hdl/csu_checker.sv */
// Port-level assertions for the counting semaphore unit, bound to its top level.
`timescale 1ns / 1ps

module csu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [csu_pkg::STATUS_W-1:0]   m_status,
    input logic [csu_pkg::COUNT_W-1:0]    m_count_after,
    input logic [csu_pkg::ID_W-1:0]       m_woken_proc,
    input logic [csu_pkg::ID_W-1:0]       m_woken_thread
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_count_after) && $stable(m_woken_proc) && $stable(m_woken_thread))
        else $error("result changed while stalled");

    // Only defined status codes appear.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= csu_pkg::STATUS_NO_CHANGE)
        else $error("undefined status code");

    // Waiter ids are reported only for a wake.
    a_ids_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != csu_pkg::STATUS_WOKEN |->
        m_woken_proc == '0 && m_woken_thread == '0)
        else $error("waiter ids without a wake");

    // Unknown, queued and woken results report a count of zero.
    a_count_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == csu_pkg::STATUS_UNKNOWN ||
                    m_status == csu_pkg::STATUS_QUEUED ||
                    m_status == csu_pkg::STATUS_WOKEN) |->
        m_count_after == '0)
        else $error("nonzero count for a result that implies zero");

    // The unit works on one item at a time, so an item never enters right
    // after another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while the previous one is in progress");

endmodule

bind counting_semaphore_unit_core csu_checker u_csu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_count_after  (m_count_after),
    .m_woken_proc   (m_woken_proc),
    .m_woken_thread (m_woken_thread)
);
